// File: rtl/atrl_pkg.sv
// atrl_pkg: shared types, constants and the cordic angle table for the
// tilt, roll and level block; no dependencies
package atrl_pkg;

    // fixed widths of the datapath
    localparam int IN_W       = 16;
    localparam int SQ_W       = 48;
    localparam int SQ_STAGES  = SQ_W / 2;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int CW         = 44;
    localparam int ZW         = 29;
    localparam int TABLE_LEN  = 24;
    localparam int TABLE_FRAC = 20;
    localparam int TILT_W     = 15;
    localparam int ROLL_W     = 17;
    localparam int LIMIT_W    = 15;
    localparam int MAG_W      = 16;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MAG     = 8'd1;

    // register reset values
    localparam logic [LIMIT_W-1:0] LEVEL_LIMIT_RST = 15'd512;
    localparam logic [MAG_W-1:0]   MIN_MAG_RST     = 16'd164;

    // one vectoring cordic lane
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    // one square root step: remainder and partial root
    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sqrt_t;

    // per-word flags carried down the pipeline
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic roll_zero;
        logic tilt_zero;
        logic low;
    } flag_t;

    // operands and flags riding along the square root cells
    typedef struct packed {
        logic [IN_W-1:0] az;
        logic [IN_W-1:0] ax;
        logic [IN_W-1:0] ay;
        flag_t           f;
    } side_t;

    // atan(2^-i) in degrees, units of 2^-20 degree
    function automatic logic [ZW-1:0] atan_entry(input int unsigned idx);
        logic [ZW-1:0] val;
        case (idx)
            0:       val = 29'd47185920;
            1:       val = 29'd27855475;
            2:       val = 29'd14718068;
            3:       val = 29'd7471121;
            4:       val = 29'd3750058;
            5:       val = 29'd1876857;
            6:       val = 29'd938658;
            7:       val = 29'd469357;
            8:       val = 29'd234682;
            9:       val = 29'd117342;
            10:      val = 29'd58671;
            11:      val = 29'd29335;
            12:      val = 29'd14668;
            13:      val = 29'd7334;
            14:      val = 29'd3667;
            15:      val = 29'd1833;
            16:      val = 29'd917;
            17:      val = 29'd458;
            18:      val = 29'd229;
            19:      val = 29'd115;
            20:      val = 29'd57;
            21:      val = 29'd29;
            22:      val = 29'd14;
            23:      val = 29'd7;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/accel_tilt_roll_level.sv
// accel_tilt_roll_level: top level, squares, magnitude test, square root
// chain, two cordic chains and the output stage; uses atrl_pkg and both cells
//
// Takes one accelerometer word (x, y, z signed 16 bit) per clock and returns
// tilt from the Z axis, roll atan2(y, x), the level flag and the low gravity
// flag, angles in 2^-ANGLE_FRAC_BITS degree. The block is a fixed pipeline:
// one squaring stage, one magnitude stage, 24 square root cells,
// CORDIC_STAGES cordic cells capped at the table length (tilt and roll lanes
// side by side) and the output register. A new word is taken every cycle;
// when a result sits in the output register and m_axis_tready is low, the
// whole chain holds and s_axis_tready drops until it is taken. The held tilt
// used for the level flag updates as each result without low gravity is
// loaded into the output register. Register writes are meant to be made
// while idle; a new minimum magnitude reaches the compare via min_mag_reg, then lim_sq_reg.
module accel_tilt_roll_level #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [atrl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [atrl_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  logic [47:0]                         s_axis_tdata,
    // result words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tilt_angle [14:0], roll_angle [31:15], is_level [32], low_gravity [33]
    output logic [39:0]                         m_axis_tdata
);
    import atrl_pkg::*;

    localparam int NCS   = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int AW    = ANGLE_FRAC_BITS + 7;
    localparam int TW    = (AW > TILT_W) ? AW : TILT_W;
    localparam int RW    = (ANGLE_FRAC_BITS + 9 > ROLL_W) ? ANGLE_FRAC_BITS + 9 : ROLL_W;
    localparam int SHIFT = TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] ZTOP  = ZW'(90 << TABLE_FRAC);
    localparam logic [ZW-1:0]        ZHALF = ZW'(1 << (SHIFT - 1));
    localparam logic [AW-1:0]        TILT90 = AW'(90 << ANGLE_FRAC_BITS);
    localparam logic signed [RW-1:0] HALF_TURN = RW'(180 << ANGLE_FRAC_BITS);

    // clamp to 0..90 degrees and round half up
    function automatic logic [AW-1:0] round_angle(input logic signed [ZW-1:0] z);
        logic [ZW-1:0] zc;
        logic [ZW-1:0] zr;
        if (z < 0)
            zc = '0;
        else if (z > ZTOP)
            zc = ZTOP;
        else
            zc = z;
        zr = zc + ZHALF;
        return zr[SHIFT +: AW];
    endfunction

    logic en;

    // configuration registers
    logic [LIMIT_W-1:0]  level_limit_reg;
    logic [MAG_W-1:0]    min_mag_reg;
    logic [2*MAG_W-1:0]  lim_sq_reg;

    // stage 1: magnitudes and squares
    logic [IN_W-1:0]     in_x, in_y, in_z;
    logic [IN_W-1:0]     abs_x, abs_y, abs_z;
    logic                v1_reg;
    logic [IN_W-1:0]     ax1_reg, ay1_reg, az1_reg;
    logic [2*IN_W-1:0]   sqx1_reg, sqy1_reg, sqz1_reg;
    logic                negx1_reg, negy1_reg, rz1_reg;

    // stage 2: magnitude test and square root operand
    logic [2*IN_W-1:0]   horiz_sq;
    logic [2*IN_W-1:0]   mag_sq;
    logic                v2_reg;
    sqrt_t               sq2_reg;
    side_t               side2_reg;

    // square root chain
    sqrt_t               sq_chain   [SQ_STAGES+1];
    side_t               side_chain [SQ_STAGES+1];
    logic                vs_reg     [SQ_STAGES];

    // cordic chains
    cordic_t             tc_chain [NCS+1];
    cordic_t             rc_chain [NCS+1];
    flag_t               cf_reg   [NCS];
    logic                vc_reg   [NCS];
    logic [ROOT_W-1:0]   root;

    // output stage
    flag_t               fin_f;
    logic [AW-1:0]       tilt_base;
    logic [AW-1:0]       roll_base;
    logic [TW-1:0]       tilt_wide;
    logic [TILT_W-1:0]   tilt_val;
    logic signed [RW-1:0] roll_mag;
    logic signed [RW-1:0] roll_wide;
    logic [TILT_W-1:0]   held_next;
    logic                level_val;
    logic [TILT_W-1:0]   held_reg;
    logic                out_valid_reg;
    logic [39:0]         out_data_reg;

    // chain moves unless a result waits in the output register
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    // configuration writes, limit squared kept ready for the compare
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_limit_reg <= LEVEL_LIMIT_RST;
            min_mag_reg     <= MIN_MAG_RST;
            lim_sq_reg      <= 32'(MIN_MAG_RST) * 32'(MIN_MAG_RST);
        end
        else
        begin
            lim_sq_reg <= 32'(min_mag_reg) * 32'(min_mag_reg);
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_LEVEL_LIMIT: level_limit_reg <= cfg_data[LIMIT_W-1:0];
                    CFG_MIN_MAG:     min_mag_reg     <= cfg_data[MAG_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // input unpack and absolute values
    assign in_x  = s_axis_tdata[15:0];
    assign in_y  = s_axis_tdata[31:16];
    assign in_z  = s_axis_tdata[47:32];
    assign abs_x = in_x[IN_W-1] ? (~in_x + 16'd1) : in_x;
    assign abs_y = in_y[IN_W-1] ? (~in_y + 16'd1) : in_y;
    assign abs_z = in_z[IN_W-1] ? (~in_z + 16'd1) : in_z;

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg   <= abs_x;
            ay1_reg   <= abs_y;
            az1_reg   <= abs_z;
            sqx1_reg  <= 32'(abs_x) * 32'(abs_x);
            sqy1_reg  <= 32'(abs_y) * 32'(abs_y);
            sqz1_reg  <= 32'(abs_z) * 32'(abs_z);
            negx1_reg <= in_x[IN_W-1];
            negy1_reg <= in_y[IN_W-1];
            rz1_reg   <= (in_x == '0) && (in_y == '0);
        end
    end

    // sums of squares, at most three times 2^30
    assign horiz_sq = sqx1_reg + sqy1_reg;
    assign mag_sq   = horiz_sq + sqz1_reg;

    // stage 2 payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq2_reg.rem            <= {horiz_sq, 16'b0};
            sq2_reg.root           <= '0;
            side2_reg.az           <= az1_reg;
            side2_reg.ax           <= ax1_reg;
            side2_reg.ay           <= ay1_reg;
            side2_reg.f.neg_x      <= negx1_reg;
            side2_reg.f.neg_y      <= negy1_reg;
            side2_reg.f.roll_zero  <= rz1_reg;
            side2_reg.f.tilt_zero  <= (horiz_sq == '0) && (az1_reg == '0);
            side2_reg.f.low        <= mag_sq < lim_sq_reg;
        end
    end

    assign sq_chain[0]   = sq2_reg;
    assign side_chain[0] = side2_reg;

    // square root cells
    for (genvar i = 0; i < SQ_STAGES; i++)
    begin : g_sqrt
        atrl_sqrt_cell #(
            .STAGE (i)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .sq_in    (sq_chain[i]),
            .side_in  (side_chain[i]),
            .sq_out   (sq_chain[i+1]),
            .side_out (side_chain[i+1])
        );
    end

    // cordic operands: roll pre-scaled by 2^16, tilt by 2^24 (the root carries 2^8)
    assign root          = sq_chain[SQ_STAGES].root[ROOT_W-1:0];
    assign tc_chain[0].x = {{(CW-40){1'b0}}, side_chain[SQ_STAGES].az, 24'b0};
    assign tc_chain[0].y = {{(CW-40){1'b0}}, root, 16'b0};
    assign tc_chain[0].z = '0;
    assign rc_chain[0].x = {{(CW-32){1'b0}}, side_chain[SQ_STAGES].ax, 16'b0};
    assign rc_chain[0].y = {{(CW-32){1'b0}}, side_chain[SQ_STAGES].ay, 16'b0};
    assign rc_chain[0].z = '0;

    // tilt and roll cordic cells side by side
    for (genvar i = 0; i < NCS; i++)
    begin : g_cordic
        atrl_cordic_cell #(
            .STAGE (i)
        ) u_tilt (
            .clk   (clk),
            .en    (en),
            .c_in  (tc_chain[i]),
            .c_out (tc_chain[i+1])
        );
        atrl_cordic_cell #(
            .STAGE (i)
        ) u_roll (
            .clk   (clk),
            .en    (en),
            .c_in  (rc_chain[i]),
            .c_out (rc_chain[i+1])
        );
    end

    // flags alongside the cordic cells
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cf_reg[0] <= side_chain[SQ_STAGES].f;
            for (int i = 1; i < NCS; i++)
            begin
                cf_reg[i] <= cf_reg[i-1];
            end
        end
    end

    // valid bits down the whole chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            for (int i = 0; i < SQ_STAGES; i++)
            begin
                vs_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NCS; i++)
            begin
                vc_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= s_axis_tvalid;
            v2_reg    <= v1_reg;
            vs_reg[0] <= v2_reg;
            for (int i = 1; i < SQ_STAGES; i++)
            begin
                vs_reg[i] <= vs_reg[i-1];
            end
            vc_reg[0] <= vs_reg[SQ_STAGES-1];
            for (int i = 1; i < NCS; i++)
            begin
                vc_reg[i] <= vc_reg[i-1];
            end
            out_valid_reg <= vc_reg[NCS-1];
        end
    end

    // final angles, quadrant fix-up and level test
    always_comb
    begin
        fin_f     = cf_reg[NCS-1];
        tilt_base = fin_f.tilt_zero ? '0 : round_angle(tc_chain[NCS].z);
        roll_base = round_angle(rc_chain[NCS].z);
        tilt_wide = fin_f.low ? TW'(TILT90) : TW'(tilt_base);
        tilt_val  = tilt_wide[TILT_W-1:0];
        roll_mag  = $signed({{(RW-AW){1'b0}}, roll_base});
        if (fin_f.neg_x)
            roll_mag = HALF_TURN - roll_mag;
        roll_wide = fin_f.neg_y ? -roll_mag : roll_mag;
        if (fin_f.roll_zero)
            roll_wide = '0;
        held_next = fin_f.low ? held_reg : tilt_val;
        level_val = held_next < level_limit_reg;
    end

    // held tilt follows each result as it is loaded, but keeps its value over low gravity results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (en && vc_reg[NCS-1])
        begin
            held_reg <= held_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {6'b0, fin_f.low, level_val, roll_wide[ROLL_W-1:0], tilt_val};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// File: rtl/atrl_sqrt_cell.sv
// atrl_sqrt_cell: one restoring square root step, one root bit per cell,
// with the side operands passed along; depends on atrl_pkg
module atrl_sqrt_cell #(
    parameter int STAGE = 0
) (
    input  logic            clk,
    input  logic            en,
    input  atrl_pkg::sqrt_t sq_in,
    input  atrl_pkg::side_t side_in,
    output atrl_pkg::sqrt_t sq_out,
    output atrl_pkg::side_t side_out
);
    import atrl_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STAGE);

    sqrt_t           sq_reg;
    sqrt_t           sq_next;
    side_t           side_reg;
    logic [SQ_W-1:0] trial;

    // trial subtract of root plus the current bit
    always_comb
    begin
        trial = sq_in.root + BIT;
        if (sq_in.rem >= trial)
        begin
            sq_next.rem  = sq_in.rem - trial;
            sq_next.root = (sq_in.root >> 1) + BIT;
        end
        else
        begin
            sq_next.rem  = sq_in.rem;
            sq_next.root = sq_in.root >> 1;
        end
    end

    // hand to the next cell
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg   <= sq_next;
            side_reg <= side_in;
        end
    end

    assign sq_out   = sq_reg;
    assign side_out = side_reg;

endmodule

// File: rtl/atrl_cordic_cell.sv
// atrl_cordic_cell: one vectoring cordic rotation with its fixed shift and
// table angle; depends on atrl_pkg
module atrl_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              clk,
    input  logic              en,
    input  atrl_pkg::cordic_t c_in,
    output atrl_pkg::cordic_t c_out
);
    import atrl_pkg::*;

    localparam logic signed [ZW-1:0] ANG = $signed(atan_entry(STAGE));

    cordic_t              c_reg;
    cordic_t              c_next;
    logic signed [CW-1:0] xi;
    logic signed [CW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    // arithmetic shifts round toward minus infinity
    always_comb
    begin
        xi = c_in.x;
        yi = c_in.y;
        zi = c_in.z;
        dx = yi >>> STAGE;
        dy = xi >>> STAGE;
        if (!yi[CW-1])
        begin
            c_next.x = xi + dx;
            c_next.y = yi - dy;
            c_next.z = zi + ANG;
        end
        else
        begin
            c_next.x = xi - dx;
            c_next.y = yi + dy;
            c_next.z = zi - ANG;
        end
    end

    // hand to the next cell
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
        end
    end

    assign c_out = c_reg;

endmodule

// File: rtl/atrl_checker.sv
// atrl_checker: port-level assertions for accel_tilt_roll_level and the
// bind that attaches them; depends on atrl_pkg
module atrl_checker #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [39:0]                         m_axis_tdata
);
    import atrl_pkg::*;

    localparam logic [TILT_W-1:0] TILT90 = TILT_W'(90 << ANGLE_FRAC_BITS);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // input side stalls exactly when a result waits
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // low gravity forces tilt to ninety degrees
    a_low_tilt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[14:0] == TILT90)
        else $error("low gravity word without ninety degree tilt");

    // configuration port never pushes back
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind accel_tilt_roll_level atrl_checker #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_atrl_checker (.*);

// File: sim/accel_tilt_roll_level_test.sv
// accel_tilt_roll_level_test: self-checking bench for the tilt, roll and level block
// depends on rtl/atrl_pkg.sv and rtl/accel_tilt_roll_level.sv; reads nothing else
`timescale 1ns / 1ps

module accel_tilt_roll_level_test;

    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int LATENCY         = 27 + CORDIC_STAGES;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_WORDS     = 150;
    localparam int NUM_PHASES      = 8;

    // register indexes outside the implemented list, writes must be ignored
    localparam logic [atrl_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
    localparam logic [atrl_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST  = 8'hFF;

    // one result word split into its fields
    typedef struct packed {
        logic [14:0] tilt;
        logic [16:0] roll;
        logic        level;
        logic        low;
    } angle_word_t;

    // angle predictor plus the queue of results still owed by the block
    class angle_scoreboard;
        logic [14:0]  level_limit;
        logic [15:0]  min_mag;
        logic [14:0]  held_tilt;
        longint       atan_q20[24];
        angle_word_t  pending_angles[$];
        int           errors;
        int           words_in;
        int           words_out;
        int           reg_writes;

        function new();
            level_limit = 15'd512;
            min_mag     = 16'd164;
            held_tilt   = '0;
            errors      = 0;
            words_in    = 0;
            words_out   = 0;
            reg_writes  = 0;
            atan_q20 = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                         938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334,
                         3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
        endfunction

        function void write_reg(logic [atrl_pkg::CFG_IDX_W-1:0] idx,
                                logic [atrl_pkg::CFG_DATA_W-1:0] val);
            reg_writes++;
            if (idx == atrl_pkg::CFG_LEVEL_LIMIT)
                level_limit = val[14:0];
            else if (idx == atrl_pkg::CFG_MIN_MAG)
                min_mag = val;
        endfunction

        // integer square root, floor
        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // first quadrant atan2(b, a) by vectoring rotations, in output angle units
        function longint vector_angle(longint a, longint b);
            longint vx;
            longint vy;
            longint acc;
            longint dx;
            longint dy;
            longint right_q20;
            if (a == 0 && b == 0)
                return 0;
            vx = a <<< 16;
            vy = b <<< 16;
            acc = 0;
            right_q20 = longint'(90) <<< 20;
            for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
            begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (vy >= 0)
                begin
                    vx += dx;
                    vy -= dy;
                    acc += atan_q20[i];
                end
                else
                begin
                    vx -= dx;
                    vy += dy;
                    acc -= atan_q20[i];
                end
            end
            if (acc < 0)
                acc = 0;
            if (acc > right_q20)
                acc = right_q20;
            return (acc + (longint'(1) <<< (19 - ANGLE_FRAC_BITS))) >>> (20 - ANGLE_FRAC_BITS);
        endfunction

        // work out the result of one accepted sample
        function void take_sample(logic signed [15:0] x, logic signed [15:0] y,
                                  logic signed [15:0] z);
            longint      sx;
            longint      sy;
            longint      sz;
            longint      ax;
            longint      ay;
            longint      az;
            longint      horiz;
            longint      mag;
            longint      lim;
            longint      angle;
            longint      half_turn;
            angle_word_t want;
            sx = x;
            sy = y;
            sz = z;
            ax = (sx < 0) ? -sx : sx;
            ay = (sy < 0) ? -sy : sy;
            az = (sz < 0) ? -sz : sz;
            horiz = ax * ax + ay * ay;
            mag   = horiz + az * az;
            lim   = longint'(min_mag) * longint'(min_mag);
            half_turn = longint'(180) <<< ANGLE_FRAC_BITS;
            words_in++;

            // tilt, forced to a right angle when gravity is too weak
            want.low = (mag < lim);
            if (want.low)
            begin
                angle = longint'(90) <<< ANGLE_FRAC_BITS;
                want.tilt = angle[14:0];
            end
            else
            begin
                angle = vector_angle(az * 256, longint'(root_floor(horiz << 16)));
                want.tilt = angle[14:0];
                held_tilt = angle[14:0];
            end

            // roll over the full circle from the first quadrant angle
            if (sx == 0 && sy == 0)
                angle = 0;
            else
            begin
                angle = vector_angle(ax, ay);
                if (sx >= 0)
                    angle = (sy >= 0) ? angle : -angle;
                else
                    angle = (sy >= 0) ? (half_turn - angle) : (angle - half_turn);
            end
            want.roll  = angle[16:0];
            want.level = (held_tilt < level_limit);
            pending_angles.push_back(want);
        endfunction

        // compare one result word against the oldest prediction
        function void check_result(logic [39:0] d);
            angle_word_t want;
            angle_word_t got;
            got.tilt  = d[14:0];
            got.roll  = d[31:15];
            got.level = d[32];
            got.low   = d[33];
            words_out++;
            if (pending_angles.size() == 0)
            begin
                errors++;
                $display("%0t: result word with none outstanding: tilt %0d roll %0d level %0b low %0b",
                         $time, got.tilt, $signed(got.roll), got.level, got.low);
                return;
            end
            want = pending_angles.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: mismatch, expected tilt %0d roll %0d level %0b low %0b,",
                         $time, want.tilt, $signed(want.roll), want.level, want.low,
                         " actual tilt %0d roll %0d level %0b low %0b",
                         got.tilt, $signed(got.roll), got.level, got.low);
            end
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [atrl_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [atrl_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    logic [47:0]                        s_axis_tdata = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // tilt_angle [14:0], roll_angle [31:15], is_level [32], low_gravity [33]
    logic [39:0]                        m_axis_tdata;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    angle_scoreboard sb = new();

    accel_tilt_roll_level #(
        .CORDIC_STAGES   (CORDIC_STAGES),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: feed the predictor and check results at each accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.take_sample(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[47:32]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, sb.pending_angles.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // offer one sample, after a random gap, and wait until it is taken
    task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 48'({$urandom, $urandom});
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // register write; the caller drops cfg_valid after the last one
    task automatic cfg_write(input logic [atrl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [atrl_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // wait for every predicted result, then let the pipeline settle
    task automatic drain_results();
        while (sb.pending_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // one axis value: zero, extremes or a value at a random scale
    function automatic logic [15:0] rand_axis();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = 16'h8000;
            2: v = 16'h7FFF;
            3: v = $signed(v) >>> $urandom_range(8, 15);
            default: v = $signed(v) >>> $urandom_range(0, 15);
        endcase
        return v;
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed samples at the reset register values
        send_sample(16'sd0, 16'sd0, 16'sd16384);
        send_sample(16'sd0, 16'sd0, -16'sd16384);
        send_sample(16'sd16384, 16'sd0, 16'sd0);
        send_sample(-16'sd16384, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd16384, 16'sd0);
        send_sample(16'sd0, -16'sd16384, 16'sd0);
        send_sample(-16'sd16384, -16'sd1, 16'sd0);
        send_sample(16'sd11585, 16'sd11585, 16'sd0);
        send_sample(16'sd0, 16'sd100, 16'sd16384);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h8000, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'h8000, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'h8000);
        send_sample(16'h7FFF, 16'h8000, 16'sd1);
        // weak gravity and the magnitude floor, including the zero vector and negative x on the axis
        send_sample(16'sd10, -16'sd10, 16'sd10);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(-16'sd1, 16'sd0, 16'sd0);
        send_sample(16'sd163, 16'sd0, 16'sd0);
        send_sample(16'sd164, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd164);
        s_axis_tvalid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            // register settings of this phase
            case (p)
                0:
                begin
                    cfg_write(atrl_pkg::CFG_LEVEL_LIMIT, 16'd0);
                    cfg_write(atrl_pkg::CFG_MIN_MAG, 16'd0);
                end
                1:
                begin
                    cfg_write(atrl_pkg::CFG_LEVEL_LIMIT, 16'd23040);
                    cfg_write(atrl_pkg::CFG_MIN_MAG, 16'hFFFF);
                end
                2:
                begin
                    cfg_write(atrl_pkg::CFG_LEVEL_LIMIT, 16'hFFFF);
                    cfg_write(atrl_pkg::CFG_MIN_MAG, 16'd164);
                end
                3:
                begin
                    cfg_write(atrl_pkg::CFG_LEVEL_LIMIT, 16'($urandom_range(0, 23040)));
                    cfg_write(atrl_pkg::CFG_MIN_MAG, 16'($urandom_range(0, 20000)));
                    cfg_write(CFG_IDX_SPARE, 16'($urandom));
                end
                4:
                begin
                    cfg_write(atrl_pkg::CFG_LEVEL_LIMIT, 16'd512);
                    cfg_write(atrl_pkg::CFG_MIN_MAG, 16'd164);
                end
                5:
                begin
                    cfg_write(atrl_pkg::CFG_LEVEL_LIMIT, 16'($urandom_range(0, 23040)));
                    cfg_write(atrl_pkg::CFG_MIN_MAG, 16'($urandom));
                end
                6:
                begin
                    cfg_write(atrl_pkg::CFG_LEVEL_LIMIT, 16'd23040);
                    cfg_write(atrl_pkg::CFG_MIN_MAG, 16'd0);
                    cfg_write(CFG_IDX_LAST, 16'hFFFF);
                end
                default:
                begin
                    cfg_write(atrl_pkg::CFG_LEVEL_LIMIT, 16'($urandom_range(0, 23040)));
                    cfg_write(atrl_pkg::CFG_MIN_MAG, 16'($urandom_range(0, 2000)));
                end
            endcase
            cfg_valid <= 1'b0;

            // idle pattern: none, sender gaps, receiver stalls, both
            case (p % 4)
                0:
                begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct  <= 81;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 81;
                end
                default:
                begin
                    send_idle_pct  <= 38;
                    recv_stall_pct <= 38;
                end
            endcase

            // zero vector with no magnitude floor gives tilt zero
            if (p == 0)
            begin
                send_sample(16'sd0, 16'sd0, 16'sd0);
                send_sample(16'sd0, 16'sd0, 16'sd0);
            end
            // long receiver hold-off so the pipeline backs up into the input
            if (p == 4)
                hold_req <= hold_req + 1;

            repeat (PHASE_WORDS) send_sample(rand_axis(), rand_axis(), rand_axis());
            s_axis_tvalid <= 1'b0;
        end

        drain_results();
        $display("%0d samples sent and %0d results checked across %0d register settings,",
                 sb.words_in, sb.words_out, NUM_PHASES + 1);
        $display("%0d register writes including ignored indexes, %0d mismatches",
                 sb.reg_writes, sb.errors);
        if (sb.errors == 0 && sb.pending_angles.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/atrl_pkg.sv
rtl/atrl_sqrt_cell.sv
rtl/atrl_cordic_cell.sv
rtl/accel_tilt_roll_level.sv
rtl/atrl_checker.sv
sim/accel_tilt_roll_level_test.sv
